// ===== rtl/scd_pkg.sv =====
// Package for the serial command decoder: character codes, defaults, types and helpers.
`timescale 1ns / 1ps
package scd_pkg;

  localparam int DIGITS_DEF = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam logic [3:0] MODE_IDLE  = 4'd0;
  localparam logic [3:0] MODE_ENTRY = 4'd4;
  localparam logic [3:0] MODE_SEVEN = 4'd7;

  localparam logic signed [15:0] NUM_RESET = 16'sd500;

  // Controls for the character buffer, issued once per processed transaction.
  typedef struct packed {
    logic push;
    logic clear;
  } buf_ctrl_t;

  // Power of ten for digit position k, wrapped to 16 bits (correct for k up to 8).
  function automatic logic [15:0] pow10_mod(input int k);
    logic [15:0] p;
    p = 16'd1;
    for (int i = 0; i < 8; i++) begin
      if (i < k) begin
        p = 16'(p * 16'd10);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/scd_rx_if.sv =====
// Channel carrying one received serial byte per transaction.
`timescale 1ns / 1ps
interface scd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/scd_result_if.sv =====
// Channel carrying one decoder result per transaction.
`timescale 1ns / 1ps
interface scd_result_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode_out;
  logic               reply_valid;
  logic [7:0]         reply_char;
  logic signed [15:0] number_out;
  logic               number_updated;

  modport source (output valid, output mode_out, output reply_valid, output reply_char,
                  output number_out, output number_updated, input ready);
  modport sink (input valid, input mode_out, input reply_valid, input reply_char,
                input number_out, input number_updated, output ready);
endinterface

// ===== rtl/serial_command_decoder_numeric.sv =====
// Top level of the serial command decoder with numeric entry.
//
//   channel  dir  payload
//   rx       in   rx_byte
//   result   out  mode_out, reply_valid, reply_char, number_out, number_updated
//
// Every byte gives one result; it passes through the input register, then the result register.
// A new byte can be taken in every cycle while the result side keeps up; a waiting result
// still lets one more byte into the input register before the input side stalls.
// A stall on the result side holds both registers; rx.ready then drops.
// Synchronous reset clears mode, entry state and character count and loads value 500.
`timescale 1ns / 1ps
module serial_command_decoder_numeric
  import scd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  scd_rx_if.sink              rx,
  scd_result_if.source        result
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               adv;

  logic [3:0]         mode;
  logic [3:0]         mode_next;
  logic               collecting;
  logic               collecting_next;
  logic signed [15:0] number_value;
  logic signed [15:0] number_next;

  logic               reply;
  logic               updated;
  logic [7:0]         reply_ch;
  buf_ctrl_t          buf_ctrl;
  logic signed [15:0] buf_value;
  logic               buf_nonempty;

  logic               res_valid;
  logic [3:0]         res_mode;
  logic               res_reply;
  logic [7:0]         res_char;
  logic signed [15:0] res_number;
  logic               res_updated;

  assign adv      = in_valid && (!res_valid || result.ready);
  assign rx.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  scd_char_buf #(
    .DIGITS(DIGITS)
  ) u_buf (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (buf_ctrl),
    .ch       (in_byte),
    .value    (buf_value),
    .nonempty (buf_nonempty)
  );

  always_comb begin
    mode_next       = mode;
    collecting_next = collecting;
    reply           = 1'b0;
    updated         = 1'b0;
    buf_ctrl.push   = 1'b0;
    buf_ctrl.clear  = 1'b0;
    if (collecting) begin
      if (in_byte == CH_NL) begin
        updated         = buf_nonempty;
        buf_ctrl.clear  = adv;
        collecting_next = 1'b0;
        mode_next       = MODE_ENTRY;
        reply           = 1'b1;
      end else begin
        buf_ctrl.push = adv;
      end
    end else if (in_byte == CH_FOUR) begin
      collecting_next = 1'b1;
      reply           = 1'b1;
    end else if ((in_byte >= CH_ONE) && (in_byte <= CH_EIGHT)) begin
      // The command digits map to their low nibble.
      mode_next = in_byte[3:0];
      reply     = 1'b1;
    end

    reply_ch = 8'h00;
    if (reply) begin
      if (mode_next == MODE_SEVEN) begin
        reply_ch = CH_SEVEN;
      end else if (collecting_next) begin
        reply_ch = CH_FOUR;
      end else begin
        reply_ch = CH_F;
      end
    end

    number_next = updated ? buf_value : number_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      collecting   <= 1'b0;
      number_value <= NUM_RESET;
    end else if (adv) begin
      mode         <= mode_next;
      collecting   <= collecting_next;
      number_value <= number_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_mode    <= mode_next;
      res_reply   <= reply;
      res_char    <= reply_ch;
      res_number  <= number_next;
      res_updated <= updated;
    end
  end

  assign result.valid          = res_valid;
  assign result.mode_out       = res_mode;
  assign result.reply_valid    = res_reply;
  assign result.reply_char     = res_char;
  assign result.number_out     = res_number;
  assign result.number_updated = res_updated;

endmodule

// ===== rtl/scd_char_buf.sv =====
// Buffer of the last entered characters and their weighted decimal value.
`timescale 1ns / 1ps
module scd_char_buf
  import scd_pkg::*;
#(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  buf_ctrl_t          ctrl,
  input  logic [7:0]         ch,
  output logic signed [15:0] value,
  output logic               nonempty
);

  localparam int CNT_W = $clog2(DIGITS + 1);

  // Entry 0 holds the newest character, so entry k carries weight 10^k.
  logic [7:0]       store [DIGITS];
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[0] <= ch;
      for (int k = 1; k < DIGITS; k++) begin
        store[k] <= store[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.push && (count != CNT_W'(DIGITS))) begin
      count <= count + 1'b1;
    end
  end

  always_comb begin
    logic [8:0]  diff;
    logic [15:0] acc;
    acc = '0;
    for (int k = 0; k < DIGITS; k++) begin
      diff = {1'b0, store[k]} - {1'b0, CH_ZERO};
      if (CNT_W'(k) < count) begin
        acc = acc + 16'({{7{diff[8]}}, diff} * pow10_mod(k));
      end
    end
    value = signed'(acc);
  end

  assign nonempty = (count != '0);

endmodule

// ===== bench/serial_command_decoder_numeric_tb.sv =====
// Self-checking testbench for the serial command decoder with numeric entry.
`timescale 1ns / 1ps
module serial_command_decoder_numeric_tb;
  import scd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 170;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0]         mode;
    logic               reply_valid;
    logic [7:0]         reply_char;
    logic signed [15:0] number;
    logic               updated;
  } decode_result_t;

  // Tracks the decoder state from the accepted bytes and holds the results still owed.
  class decoder_scoreboard;
    logic [3:0]     mode;
    bit             collecting;
    logic [7:0]     entry_chars[$];
    logic [15:0]    number_value;
    decode_result_t owed_q[$];
    int             errors;
    int             n_bytes;
    int             n_results;
    int             n_replies;
    int             n_updates;
    int             n_empty_entries;
    int             n_overflows;

    function new();
      mode = MODE_IDLE;
      collecting = 0;
      number_value = NUM_RESET;
    endfunction

    function void note_byte(logic [7:0] b);
      decode_result_t r;
      bit             reply;
      bit             upd;
      logic [15:0]    acc;
      logic [15:0]    digit;
      reply = 0;
      upd = 0;
      n_bytes++;
      if (collecting) begin
        if (b == CH_NL) begin
          if (entry_chars.size() > 0) begin
            acc = 16'd0;
            // The oldest kept character carries the highest weight.
            foreach (entry_chars[i]) begin
              digit = {8'd0, entry_chars[i]} - {8'd0, CH_ZERO};
              acc = acc * 16'd10 + digit;
            end
            number_value = acc;
            upd = 1;
          end else begin
            n_empty_entries++;
          end
          entry_chars.delete();
          collecting = 0;
          mode = MODE_ENTRY;
          reply = 1;
        end else begin
          entry_chars.push_back(b);
          if (entry_chars.size() > DIGITS_DEF) begin
            void'(entry_chars.pop_front());
            n_overflows++;
          end
        end
      end else if (b == CH_FOUR) begin
        collecting = 1;
        reply = 1;
      end else if (b >= CH_ONE && b <= CH_EIGHT) begin
        mode = 4'(b - CH_ZERO);
        reply = 1;
      end
      r.mode = mode;
      r.reply_valid = reply;
      if (!reply) r.reply_char = 8'h00;
      else if (mode == MODE_SEVEN) r.reply_char = CH_SEVEN;
      else if (collecting) r.reply_char = CH_FOUR;
      else r.reply_char = CH_F;
      r.number = number_value;
      r.updated = upd;
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [3:0] m, logic rv, logic [7:0] rc,
                               logic signed [15:0] num, logic upd);
      decode_result_t e;
      n_results++;
      if (rv === 1'b1) n_replies++;
      if (upd === 1'b1) n_updates++;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Result %0d arrived with nothing expected: mode %0d reply %0b/%h number %0d",
                   n_results, m, rv, rc, num);
        return;
      end
      e = owed_q.pop_front();
      if (m !== e.mode || rv !== e.reply_valid || rc !== e.reply_char ||
          num !== e.number || upd !== e.updated) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("Result %0d mismatch: expected mode %0d reply %0b/%h number %0d upd %0b, got mode %0d reply %0b/%h number %0d upd %0b",
                   n_results, e.mode, e.reply_valid, e.reply_char, e.number, e.updated,
                   m, rv, rc, num, upd);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   idle_cycles;
  decoder_scoreboard sb;

  scd_rx_if     rx ();
  scd_result_if result ();

  serial_command_decoder_numeric u_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Transactions are observed at the rising edge; the watchdog counts edges without any.
  always @(posedge clk) begin
    if (!rst) begin
      if (rx.valid && rx.ready) sb.note_byte(rx.rx_byte);
      if (result.valid && result.ready)
        sb.check_result(result.mode_out, result.reply_valid, result.reply_char,
                        result.number_out, result.number_updated);
      if ((rx.valid && rx.ready) || (result.valid && result.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    rx.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Mostly complete entries and mode commands, with some noise and unterminated entries.
  task automatic send_random_sequence(inout int sent);
    int         kind;
    int         len;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      send_byte(CH_FOUR);
      sent++;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
      repeat (len) begin
        if ($urandom_range(0, 9) < 8) c = CH_ZERO + 8'($urandom_range(0, 9));
        else c = 8'($urandom_range(0, 255));
        send_byte(c);
        sent++;
      end
      if ($urandom_range(0, 19) != 0) begin
        send_byte(CH_NL);
        sent++;
      end
    end else if (kind < 85) begin
      c = 8'($urandom_range(1, 7));
      if (c >= 8'd4) c++;
      send_byte(CH_ZERO + c);
      sent++;
    end else begin
      send_byte(8'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    int         sent;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    result.ready = 1'b0;
    rst = 1'b1;
    idle_cycles = 0;
    send_gap_pct = 11;
    recv_stall_pct = 64;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Noise and a newline outside entry, every mode command, entry under mode 7 with
    // overflow, an empty entry, and an entry of non-digit characters.
    directed = '{8'h00, 8'hFF, CH_NL,
                 8'h31, 8'h32, 8'h33, 8'h35, 8'h36, 8'h38, CH_SEVEN,
                 CH_FOUR, 8'h39, 8'h38, 8'h37, 8'h36, 8'h35, CH_NL,
                 CH_FOUR, CH_NL,
                 CH_FOUR, 8'hFF, 8'h00, CH_NL};
    foreach (directed[i]) send_byte(directed[i]);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 11;
          recv_stall_pct = 64;
        end
        1: begin
          send_gap_pct = 64;
          recv_stall_pct = 11;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_sequence(sent);
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d bytes and %0d results: %0d replies, %0d value updates,",
             sb.n_bytes, sb.n_results, sb.n_replies, sb.n_updates);
    $display("%0d empty entries and %0d dropped overflow characters under three stall mixes.",
             sb.n_empty_entries, sb.n_overflows);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results outstanding", sb.errors, sb.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
